/* src/arrf_pkg.sv */
// Shared types and constants for the antialiased rounded rectangle fill unit.
// Used by the front, queue, back and top level files; depends on nothing.
package arrf_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int COLOR_W = 24;
  localparam int PIXEL_W = 32;
  localparam int RAD_W   = 12;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 4'd7;

  // Depth of the queue between front and back (a power of two).
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Rectangle settings as seen by the datapath; rad is the clamped radius.
  typedef struct packed {
    logic signed [DIM_W-1:0] origin_x;
    logic signed [DIM_W-1:0] origin_y;
    logic [DIM_W-1:0]        rect_w;
    logic [DIM_W-1:0]        rect_h;
    logic [RAD_W-1:0]        rad;
    logic [COLOR_W-1:0]      fill;
  } rect_cfg_t;

  // One classified pixel on its way from front to back.
  typedef struct packed {
    logic               paint;
    logic               corner;
    logic [RAD_W-1:0]   dx;
    logic [RAD_W-1:0]   dy;
    logic [PIXEL_W-1:0] dest;
  } item_t;

endpackage

/* src/arrf_front.sv */
// Front classifier: rectangle and screen clipping, corner detection and arc offsets.
// Depends on arrf_pkg.
module arrf_front #(
  parameter int SCR_BITS = 13
) (
  input  logic [arrf_pkg::COORD_W-1:0] col,
  input  logic [arrf_pkg::COORD_W-1:0] row,
  input  logic [arrf_pkg::PIXEL_W-1:0] dest,
  input  arrf_pkg::rect_cfg_t          cfg,
  input  logic [SCR_BITS-1:0]          scr_w,
  input  logic [SCR_BITS-1:0]          scr_h,
  output arrf_pkg::item_t              item
);

  // Returns {hit, offset}: hit when pos lies in the near or far corner band.
  function automatic logic [arrf_pkg::RAD_W:0] corner_offset(
    input logic [arrf_pkg::COORD_W-1:0] pos,
    input logic [arrf_pkg::DIM_W-1:0]   len,
    input logic [arrf_pkg::RAD_W-1:0]   rad
  );
    logic [arrf_pkg::DIM_W-1:0] far_start;
    logic [arrf_pkg::DIM_W-1:0] p;
    logic [arrf_pkg::DIM_W-1:0] off;
    far_start = len - {1'b0, rad};
    p = {1'b0, pos};
    if (p < {1'b0, rad}) begin
      corner_offset = {1'b1, rad - pos};
    end else if (p >= far_start) begin
      off = p - far_start + 13'd1;
      corner_offset = {1'b1, off[arrf_pkg::RAD_W-1:0]};
    end else begin
      corner_offset = '0;
    end
  endfunction

  logic signed [arrf_pkg::DIM_W:0] sx;
  logic signed [arrf_pkg::DIM_W:0] sy;
  logic [SCR_BITS-1:0]             sx_u;
  logic [SCR_BITS-1:0]             sy_u;
  logic                            in_rect;
  logic                            onscreen;
  logic [arrf_pkg::RAD_W:0]        hx;
  logic [arrf_pkg::RAD_W:0]        hy;

  always_comb begin
    sx = {cfg.origin_x[arrf_pkg::DIM_W-1], cfg.origin_x} + $signed({2'b00, col});
    sy = {cfg.origin_y[arrf_pkg::DIM_W-1], cfg.origin_y} + $signed({2'b00, row});
    // A non-negative screen coordinate always fits the low 13 bits.
    sx_u = SCR_BITS'(sx[arrf_pkg::DIM_W-1:0]);
    sy_u = SCR_BITS'(sy[arrf_pkg::DIM_W-1:0]);
    in_rect = ({1'b0, col} < cfg.rect_w) && ({1'b0, row} < cfg.rect_h);
    onscreen = !sx[arrf_pkg::DIM_W] && !sy[arrf_pkg::DIM_W] &&
               (sx_u < scr_w) && (sy_u < scr_h);
    hx = corner_offset(col, cfg.rect_w, cfg.rad);
    hy = corner_offset(row, cfg.rect_h, cfg.rad);
    item.paint  = in_rect && onscreen;
    item.corner = hx[arrf_pkg::RAD_W] && hy[arrf_pkg::RAD_W];
    item.dx     = hx[arrf_pkg::RAD_W-1:0];
    item.dy     = hy[arrf_pkg::RAD_W-1:0];
    item.dest   = dest;
  end

endmodule

/* src/arrf_queue.sv */
// Short queue of classified pixels between the front and the back pipeline.
// Depends on arrf_pkg.
module arrf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  arrf_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd_en,
  output arrf_pkg::item_t rd_item,
  output logic            q_empty
);

  arrf_pkg::item_t               slot_r [arrf_pkg::Q_DEPTH];
  logic [arrf_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [arrf_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [arrf_pkg::Q_PTR_W:0]    count_r, count_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign q_full  = (count_r == (arrf_pkg::Q_PTR_W+1)'(arrf_pkg::Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (arrf_pkg::Q_PTR_W+1)'(do_wr) - (arrf_pkg::Q_PTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* src/arrf_back.sv */
// Back pipeline: squared distance, bit-per-stage square root, edge alpha and blend.
// Depends on arrf_pkg; the final stage is the result register.
module arrf_back #(
  parameter int FRAC = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arrf_pkg::rect_cfg_t          cfg,
  input  logic                         q_empty,
  input  arrf_pkg::item_t              q_item,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic                         out_write_enable,
  output logic [arrf_pkg::PIXEL_W-1:0] out_new_pixel
);

  localparam int NB    = 13 + FRAC;       // root bits
  localparam int RW    = NB + 2;          // remainder bits
  localparam int VW    = 2 * NB;          // radicand bits
  localparam int SUM_W = 25;
  localparam int R_W   = NB + 1;

  typedef struct packed {
    logic                         paint;
    logic                         corner;
    logic [arrf_pkg::PIXEL_W-1:0] dest;
  } ctx_t;

  logic adv;
  logic out_v_r;

  assign adv   = !out_v_r || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_v_r;

  // Squares of the arc offsets.
  logic        a_v_r;
  ctx_t        a_ctx_r;
  logic [23:0] a_sqx_r, a_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctx_r <= '{paint: q_item.paint, corner: q_item.corner, dest: q_item.dest};
      a_sqx_r <= {12'd0, q_item.dx} * {12'd0, q_item.dy ^ q_item.dy ^ q_item.dx};
      a_sqy_r <= {12'd0, q_item.dy} * {12'd0, q_item.dy};
    end
  end

  // Sum of squares.
  logic             s_v_r;
  ctx_t             s_ctx_r;
  logic [SUM_W-1:0] s_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (adv) begin
      s_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_ctx_r <= a_ctx_r;
      s_sum_r <= {1'b0, a_sqx_r} + {1'b0, a_sqy_r};
    end
  end

  // Square root, one result bit per stage.
  logic          sq_v_r    [NB];
  ctx_t          sq_ctx_r  [NB];
  logic [RW-1:0] sq_rem_r  [NB];
  logic [NB-1:0] sq_root_r [NB];
  logic [VW-1:0] sq_val_r  [NB];

  logic          src_v    [NB];
  ctx_t          src_ctx  [NB];
  logic [RW-1:0] src_rem  [NB];
  logic [NB-1:0] src_root [NB];
  logic [VW-1:0] src_val  [NB];

  always_comb begin
    src_v[0]    = s_v_r;
    src_ctx[0]  = s_ctx_r;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_val[0]  = {1'b0, s_sum_r, {(2*FRAC){1'b0}}};
    for (int k = 1; k < NB; k++) begin
      src_v[k]    = sq_v_r[k-1];
      src_ctx[k]  = sq_ctx_r[k-1];
      src_rem[k]  = sq_rem_r[k-1];
      src_root[k] = sq_root_r[k-1];
      src_val[k]  = sq_val_r[k-1];
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_sqrt
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_sub;
    logic          take;

    assign rem_sh  = {src_rem[k], src_val[k][VW-1 -: 2]};
    assign trial   = {2'b00, src_root[k], 2'b01};
    assign take    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx_r[k]  <= src_ctx[k];
        sq_rem_r[k]  <= take ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        sq_root_r[k] <= {src_root[k][NB-2:0], take};
        sq_val_r[k]  <= {src_val[k][VW-3:0], 2'b00};
      end
    end
  end

  // Threshold compare and edge alpha.
  logic                 t_v_r;
  ctx_t                 t_ctx_r;
  logic                 t_we_r;
  logic [7:0]           t_alpha_r;

  logic [NB-1:0]        root_d;
  logic [R_W-1:0]       r_fix;
  logic [R_W-1:0]       r_hi;
  logic                 far_out;
  logic                 near_edge;
  logic [R_W-1:0]       r_dif;
  logic [FRAC+7:0]      a_prod;
  logic [7:0]           a_val;
  logic                 skip;
  logic [7:0]           alpha;
  logic                 we;

  always_comb begin
    root_d    = sq_root_r[NB-1];
    r_fix     = R_W'({cfg.rad, {FRAC{1'b0}}});
    r_hi      = r_fix + R_W'(1 << (FRAC - 1));
    far_out   = ({1'b0, root_d} > r_hi);
    near_edge = ({1'b0, root_d} + R_W'(1 << (FRAC - 1))) > r_fix;
    r_dif     = r_hi - {1'b0, root_d};
    // Times 255 as a shift and a subtract.
    a_prod    = {r_dif[FRAC-1:0], 8'd0} - {8'd0, r_dif[FRAC-1:0]};
    a_val     = a_prod[FRAC+7:FRAC];
    skip      = sq_ctx_r[NB-1].corner && (far_out || (near_edge && (a_val == 8'd0)));
    alpha     = (sq_ctx_r[NB-1].corner && near_edge) ? a_val : 8'd255;
    we        = sq_ctx_r[NB-1].paint && !skip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (adv) begin
      t_v_r <= sq_v_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ctx_r   <= sq_ctx_r[NB-1];
      t_we_r    <= we;
      t_alpha_r <= alpha;
    end
  end

  // Blend products; an alpha of 255 reproduces the fill byte exactly.
  logic        m_v_r;
  logic        m_we_r;
  logic [31:0] m_dest_r;
  logic [15:0] m_sum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_we_r   <= t_we_r;
      m_dest_r <= t_ctx_r.dest;
      for (int c = 0; c < 3; c++) begin
        m_sum_r[c] <= {8'd0, cfg.fill[8*c +: 8]} * {8'd0, t_alpha_r} +
                      {8'd0, t_ctx_r.dest[8 + 8*c +: 8]} * {8'd0, 8'd255 - t_alpha_r};
      end
    end
  end

  // Divide by 255 through a reciprocal multiply, exact for 16-bit sums.
  logic [31:0] q_prod [3];
  logic [23:0] q_rgb;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_prod[c]        = {16'd0, m_sum_r[c]} * 32'h0000_8081;
      q_rgb[8*c +: 8]  = q_prod[c][30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_write_enable <= m_we_r;
      out_new_pixel    <= m_we_r ? {q_rgb, 8'h00} : m_dest_r;
    end
  end

endmodule

/* src/antialiased_rounded_rect_fill_unit.sv */
// Top level of the antialiased rounded rectangle fill unit: configuration registers,
// front classifier, queue and back pipeline. Depends on arrf_pkg and the arrf_ modules.
//
// The unit takes one pixel per clock while full is low and returns exactly one result
// per pixel, in order: a write enable and the word to write, which equals the incoming
// framebuffer word when no write is needed. Both sides look like queues; a pixel goes in
// with push while full is low and a result is taken with pop while empty is low. An
// accepted pixel passes the queue slot, then the square, sum, square-root, threshold and
// blend registers and the result register, which takes the divide. The square-root
// pipeline resolves one bit of the distance per stage. The pipeline is fully pipelined,
// so the sustained rate is one pixel per clock while the consumer pops every cycle. When
// the consumer stalls, the back pipeline holds and the front keeps accepting into a
// four-entry queue until it fills. Configuration writes are always accepted (cfg_ready
// is tied high) and must only be made while no pixel is in flight; the corner radius is
// clamped to half the height and half the width on the fly.
module antialiased_rounded_rect_fill_unit #(
  parameter int MAX_DIM        = 4096,
  parameter int SQRT_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Pixel input
  input  logic                           push,
  output logic                           full,
  input  logic [arrf_pkg::COORD_W-1:0]   in_col_in_rect,
  input  logic [arrf_pkg::COORD_W-1:0]   in_row_in_rect,
  input  logic [arrf_pkg::PIXEL_W-1:0]   in_dest_pixel,
  // Result output
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_write_enable,
  output logic [arrf_pkg::PIXEL_W-1:0]   out_new_pixel,
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arrf_pkg::COLOR_W-1:0]   cfg_data
);

  // The clip registers must also hold the reset size, which may exceed 13 bits.
  localparam int SCR_BITS = ($clog2(MAX_DIM + 1) > arrf_pkg::DIM_W) ?
                            $clog2(MAX_DIM + 1) : arrf_pkg::DIM_W;

  logic signed [arrf_pkg::DIM_W-1:0] origin_x_r;
  logic signed [arrf_pkg::DIM_W-1:0] origin_y_r;
  logic [arrf_pkg::DIM_W-1:0]        rect_w_r;
  logic [arrf_pkg::DIM_W-1:0]        rect_h_r;
  logic [arrf_pkg::DIM_W-1:0]        radius_r;
  logic [arrf_pkg::COLOR_W-1:0]      fill_r;
  logic [SCR_BITS-1:0]               scr_w_r;
  logic [SCR_BITS-1:0]               scr_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      rect_w_r   <= '0;
      rect_h_r   <= '0;
      radius_r   <= '0;
      fill_r     <= '0;
      scr_w_r    <= SCR_BITS'(MAX_DIM);
      scr_h_r    <= SCR_BITS'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arrf_pkg::CFG_ORIGIN_X:      origin_x_r <= cfg_data[arrf_pkg::DIM_W-1:0];
        arrf_pkg::CFG_ORIGIN_Y:      origin_y_r <= cfg_data[arrf_pkg::DIM_W-1:0];
        arrf_pkg::CFG_RECT_WIDTH:    rect_w_r   <= cfg_data[arrf_pkg::DIM_W-1:0];
        arrf_pkg::CFG_RECT_HEIGHT:   rect_h_r   <= cfg_data[arrf_pkg::DIM_W-1:0];
        arrf_pkg::CFG_CORNER_RADIUS: radius_r   <= cfg_data[arrf_pkg::DIM_W-1:0];
        arrf_pkg::CFG_FILL_COLOR:    fill_r     <= cfg_data;
        arrf_pkg::CFG_SCREEN_WIDTH:  scr_w_r    <= SCR_BITS'(cfg_data[arrf_pkg::DIM_W-1:0]);
        arrf_pkg::CFG_SCREEN_HEIGHT: scr_h_r    <= SCR_BITS'(cfg_data[arrf_pkg::DIM_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Clamp the radius to half the height first, then to half the width. The result is at
  // most half of a 13-bit width, so it fits 12 bits.
  logic [arrf_pkg::DIM_W-1:0] rad_h;
  logic [arrf_pkg::DIM_W-1:0] rad_hw;
  arrf_pkg::rect_cfg_t        cfg;

  always_comb begin
    rad_h  = (radius_r > (rect_h_r >> 1)) ? (rect_h_r >> 1) : radius_r;
    rad_hw = (rad_h > (rect_w_r >> 1)) ? (rect_w_r >> 1) : rad_h;
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.rect_w   = rect_w_r;
    cfg.rect_h   = rect_h_r;
    cfg.rad      = rad_hw[arrf_pkg::RAD_W-1:0];
    cfg.fill     = fill_r;
  end

  // Front: classify the incoming pixel straight into the queue.
  arrf_pkg::item_t front_item;
  arrf_pkg::item_t q_item;
  logic            q_empty;
  logic            q_pop;

  arrf_front #(
    .SCR_BITS(SCR_BITS)
  ) u_front (
    .col   (in_col_in_rect),
    .row   (in_row_in_rect),
    .dest  (in_dest_pixel),
    .cfg   (cfg),
    .scr_w (scr_w_r),
    .scr_h (scr_h_r),
    .item  (front_item)
  );

  arrf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (front_item),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .q_empty (q_empty)
  );

  // Back: distance, alpha and blend, ending in the result register.
  arrf_back #(
    .FRAC(SQRT_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_write_enable (out_write_enable),
    .out_new_pixel    (out_new_pixel)
  );

endmodule

/* tb/arrf_fill_checker.sv */
// Checker for the antialiased rounded rectangle fill unit: keeps its own copy of the
// settings, predicts every accepted pixel and compares the results in order.
// Depends on arrf_pkg for field widths and register indexes.
module arrf_fill_checker
  import arrf_pkg::*;
#(
  parameter int MAX_DIM        = 4096,
  parameter int SQRT_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic [COORD_W-1:0]   in_col_in_rect,
  input  logic [COORD_W-1:0]   in_row_in_rect,
  input  logic [PIXEL_W-1:0]   in_dest_pixel,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 out_write_enable,
  input  logic [PIXEL_W-1:0]   out_new_pixel,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               we;
    logic [PIXEL_W-1:0] px;
  } pixel_result_t;

  logic signed [DIM_W-1:0] org_x, org_y;
  logic [DIM_W-1:0]        width_px, height_px, radius_req, scr_w, scr_h;
  logic [COLOR_W-1:0]      fill_rgb;

  pixel_result_t pixel_predictions[$];
  int unsigned   fail_tally;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic pixel_result_t predict_fill(input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] row,
                                                 input logic [PIXEL_W-1:0] dest);
    longint i, j, w, h, rad, sx, sy, dx, dy;
    longint unsigned sq, root_fx, r_fx, half, a;
    logic [PIXEL_W-1:0] full_word;
    int unsigned alpha, sc, dc;
    bit skip;
    pixel_result_t res;
    i = longint'(col);
    j = longint'(row);
    w = longint'(width_px);
    h = longint'(height_px);
    rad = longint'(radius_req);
    if (rad > h / 2) rad = h / 2;
    if (rad > w / 2) rad = w / 2;
    sx = longint'(org_x) + i;
    sy = longint'(org_y) + j;
    full_word = {fill_rgb, 8'h00};
    res.we = 1'b0;
    res.px = dest;
    if (i < w && j < h && sx >= 0 && sy >= 0 &&
        sx < longint'(scr_w) && sy < longint'(scr_h)) begin
      dx = -1;
      dy = -1;
      alpha = 255;
      skip = 1'b0;
      if (i < rad) dx = rad - i;
      else if (i >= w - rad) dx = i - (w - rad - 1);
      if (j < rad) dy = rad - j;
      else if (j >= h - rad) dy = j - (h - rad - 1);
      // Only pixels in one of the four corner squares see the arc.
      if (dx >= 0 && dy >= 0) begin
        sq = dx * dx + dy * dy;
        root_fx = floor_sqrt(sq << (2 * SQRT_FRAC_BITS));
        r_fx = rad << SQRT_FRAC_BITS;
        half = 64'd1 << (SQRT_FRAC_BITS - 1);
        if (root_fx > r_fx + half) begin
          skip = 1'b1;
        end else if (root_fx + half > r_fx) begin
          a = ((r_fx + half - root_fx) * 255) >> SQRT_FRAC_BITS;
          if (a == 0) skip = 1'b1;
          else if (a < 255) alpha = int'(a);
        end
      end
      if (!skip) begin
        res.we = 1'b1;
        if (alpha >= 255) begin
          res.px = full_word;
        end else begin
          res.px = '0;
          for (int ch = 1; ch < 4; ch++) begin
            sc = full_word[8*ch +: 8];
            dc = dest[8*ch +: 8];
            res.px[8*ch +: 8] = 8'((sc * alpha + dc * (255 - alpha)) / 255);
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pixel_result_t want;
    if (!rst_n) begin
      org_x      <= '0;
      org_y      <= '0;
      width_px   <= '0;
      height_px  <= '0;
      radius_req <= '0;
      fill_rgb   <= '0;
      scr_w      <= DIM_W'(MAX_DIM);
      scr_h      <= DIM_W'(MAX_DIM);
      pixel_predictions.delete();
      fail_tally = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X:      org_x      <= cfg_data[DIM_W-1:0];
          CFG_ORIGIN_Y:      org_y      <= cfg_data[DIM_W-1:0];
          CFG_RECT_WIDTH:    width_px   <= cfg_data[DIM_W-1:0];
          CFG_RECT_HEIGHT:   height_px  <= cfg_data[DIM_W-1:0];
          CFG_CORNER_RADIUS: radius_req <= cfg_data[DIM_W-1:0];
          CFG_FILL_COLOR:    fill_rgb   <= cfg_data;
          CFG_SCREEN_WIDTH:  scr_w      <= cfg_data[DIM_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h      <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pixel_predictions.size() == 0) begin
          $error("result with no pixel pending: write_enable %0d new_pixel %h",
                 out_write_enable, out_new_pixel);
          fail_tally++;
        end else begin
          want = pixel_predictions.pop_front();
          if (out_write_enable !== want.we) begin
            $error("write_enable: expected %0d, actual %0d", want.we, out_write_enable);
            fail_tally++;
          end
          if (out_new_pixel !== want.px) begin
            $error("new_pixel: expected %h, actual %h", want.px, out_new_pixel);
            fail_tally++;
          end
        end
      end
      if (push && !full)
        pixel_predictions.push_back(predict_fill(in_col_in_rect, in_row_in_rect,
                                                 in_dest_pixel));
    end
    mismatches  <= fail_tally;
    outstanding <= pixel_predictions.size();
  end

endmodule

/* tb/antialiased_rounded_rect_fill_unit_tb.sv */
// Top of the testbench for the antialiased rounded rectangle fill unit: clock, reset,
// settings, pixel stimulus, result pops and the verdict. Depends on arrf_pkg, the unit
// and arrf_fill_checker, which does all prediction and comparison.
module antialiased_rounded_rect_fill_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arrf_pkg::*;

  localparam int MAX_DIM        = 4096;
  localparam int SQRT_FRAC_BITS = 8;
  // Input to result delay of the unit; used for the quiet time before
  // settings change and at the end.
  localparam int LATENCY        = 18 + SQRT_FRAC_BITS;
  localparam int QUIET          = LATENCY + 8;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 95;
  localparam int PHASES         = 6;
  // An index past the last register; the unit must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 push           = 1'b0;
  logic                 full;
  logic [COORD_W-1:0]   in_col_in_rect = '0;
  logic [COORD_W-1:0]   in_row_in_rect = '0;
  logic [PIXEL_W-1:0]   in_dest_pixel  = '0;
  logic                 empty;
  logic                 pop            = 1'b0;
  logic                 out_write_enable;
  logic [PIXEL_W-1:0]   out_new_pixel;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [COLOR_W-1:0]   cfg_data       = '0;

  int unsigned mismatches, outstanding;

  // Idle chances in percent for each side, and a request for one long receiver stall.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  bit          long_hold_req = 1'b0;

  // What the stimulus knows of the current rectangle, to aim pixels at the corners.
  int cur_w, cur_h, cur_rad;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  antialiased_rounded_rect_fill_unit #(
    .MAX_DIM        (MAX_DIM),
    .SQRT_FRAC_BITS (SQRT_FRAC_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_col_in_rect   (in_col_in_rect),
    .in_row_in_rect   (in_row_in_rect),
    .in_dest_pixel    (in_dest_pixel),
    .empty            (empty),
    .pop              (pop),
    .out_write_enable (out_write_enable),
    .out_new_pixel    (out_new_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  arrf_fill_checker #(
    .MAX_DIM        (MAX_DIM),
    .SQRT_FRAC_BITS (SQRT_FRAC_BITS)
  ) fill_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_col_in_rect   (in_col_in_rect),
    .in_row_in_rect   (in_row_in_rect),
    .in_dest_pixel    (in_dest_pixel),
    .empty            (empty),
    .pop              (pop),
    .out_write_enable (out_write_enable),
    .out_new_pixel    (out_new_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // A 13-bit register value in the 24-bit data word. Half of the time the unused upper
  // bits carry junk, which the unit has to drop.
  function automatic logic [COLOR_W-1:0] pad13(input int value);
    logic [COLOR_W-1:0] word;
    word = COLOR_W'($urandom);
    if ($urandom_range(0, 1) == 0) word[COLOR_W-1:DIM_W] = '0;
    word[DIM_W-1:0] = value[DIM_W-1:0];
    return word;
  endfunction

  // Presents one register write and waits for its request to be taken. Valid is left
  // high so that back-to-back writes never lower and raise it in the same step.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register. Only called while nothing is in flight.
  task automatic write_setting(input int ox, input int oy, input int w, input int h,
                               input int rad, input int fill, input int sw, input int sh,
                               input bit poke_unused);
    set_reg(CFG_ORIGIN_X, pad13(ox));
    set_reg(CFG_ORIGIN_Y, pad13(oy));
    set_reg(CFG_RECT_WIDTH, pad13(w));
    set_reg(CFG_RECT_HEIGHT, pad13(h));
    set_reg(CFG_CORNER_RADIUS, pad13(rad));
    set_reg(CFG_FILL_COLOR, fill[COLOR_W-1:0]);
    set_reg(CFG_SCREEN_WIDTH, pad13(sw));
    set_reg(CFG_SCREEN_HEIGHT, pad13(sh));
    if (poke_unused) set_reg(CFG_UNUSED_LAST, COLOR_W'($urandom));
    cfg_valid <= 1'b0;
    // Mirror the unit's clamping so that corner pixels can be aimed at.
    cur_w   = w & 13'h1FFF;
    cur_h   = h & 13'h1FFF;
    cur_rad = rad & 13'h1FFF;
    if (cur_rad > cur_h / 2) cur_rad = cur_h / 2;
    if (cur_rad > cur_w / 2) cur_rad = cur_w / 2;
  endtask

  // Offers one pixel, after a random number of idle cycles, and returns at the edge where
  // its request is accepted. Push is left high for the next pixel.
  task automatic send_pixel(input int col, input int row, input logic [PIXEL_W-1:0] dest);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_col_in_rect <= col[COORD_W-1:0];
    in_row_in_rect <= row[COORD_W-1:0];
    in_dest_pixel  <= dest;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Waits until every predicted result has been popped, then a quiet stretch. The first
  // edge lets the checker count a pixel accepted at the calling edge.
  task automatic drain_results(input int quiet);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  // Draws a fresh setting: mostly small rectangles near the origin so that pixels land on
  // screen, sometimes anything the register widths allow.
  task automatic random_setting();
    int ox, oy, w, h, rad, sw, sh, pick;
    pick = $urandom_range(0, 9);
    w = (pick < 7) ? $urandom_range(1, 200) : (pick < 9) ? $urandom_range(0, 4096)
                                                        : $urandom_range(0, 8191);
    pick = $urandom_range(0, 9);
    h = (pick < 7) ? $urandom_range(1, 200) : (pick < 9) ? $urandom_range(0, 4096)
                                                        : $urandom_range(0, 8191);
    pick = $urandom_range(0, 9);
    rad = (pick < 6) ? $urandom_range(0, 100) : (pick < 9) ? $urandom_range(0, 4096)
                                                          : $urandom_range(0, 8191);
    pick = $urandom_range(0, 9);
    ox = (pick < 7) ? $urandom_range(0, 50) : (pick < 9) ? $urandom_range(0, 60) - 60
                                                        : $urandom_range(0, 8191) - 4096;
    pick = $urandom_range(0, 9);
    oy = (pick < 7) ? $urandom_range(0, 50) : (pick < 9) ? $urandom_range(0, 60) - 60
                                                        : $urandom_range(0, 8191) - 4096;
    pick = $urandom_range(0, 9);
    sw = (pick < 7) ? MAX_DIM : (pick < 9) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
    pick = $urandom_range(0, 9);
    sh = (pick < 7) ? MAX_DIM : (pick < 9) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
    write_setting(ox, oy, w, h, rad, $urandom_range(0, 24'hFFFFFF), sw, sh,
                  $urandom_range(0, 3) == 0);
  endtask

  // Chooses a pixel position: most fall in a corner square, where the arc and the blend
  // are decided, some anywhere in the rectangle, the rest anywhere in the field range.
  task automatic random_pixel(output int col, output int row);
    int pick;
    pick = $urandom_range(0, 99);
    if (cur_w == 0 || cur_h == 0 || pick >= 85) begin
      col = $urandom_range(0, 4095);
      row = $urandom_range(0, 4095);
    end else if (pick < 60 && cur_rad > 0) begin
      col = $urandom_range(0, cur_rad);
      row = $urandom_range(0, cur_rad);
      if ($urandom_range(0, 1)) col = cur_w - 1 - col;
      if ($urandom_range(0, 1)) row = cur_h - 1 - row;
    end else begin
      col = $urandom_range(0, cur_w - 1);
      row = $urandom_range(0, cur_h - 1);
    end
    if (col > 4095) col = 4095;
    if (row > 4095) row = 4095;
  endtask

  // Receiver: pops at random, and on request holds off for a long stretch so that the
  // unit backs up all the way to its input.
  initial begin : take_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= take_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int col, row;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Light idling on the sender, heavy on the receiver.
    send_idle_pct = 7;
    take_idle_pct = 60;

    // A 40 by 30 rectangle with radius 8: corners outside the arc, on the antialiased
    // band, inside the arc, plain interior and positions past the right and bottom edges.
    write_setting(0, 0, 40, 30, 8, 24'hA53CF0, MAX_DIM, MAX_DIM, 1'b1);
    send_pixel(0, 0, 32'hFFFFFFFF);
    send_pixel(1, 1, 32'h00000000);
    send_pixel(2, 2, 32'hFFFFFFFF);
    send_pixel(0, 7, 32'h12345678);
    send_pixel(2, 3, 32'h00000000);
    send_pixel(3, 1, 32'hDEADBEEF);
    send_pixel(0, 8, 32'h00000000);
    send_pixel(36, 26, 32'hFFFFFFFF);
    send_pixel(39, 29, 32'h87654321);
    send_pixel(33, 28, 32'hFFFFFFFF);
    send_pixel(20, 15, 32'h00000000);
    send_pixel(40, 0, 32'hCAFEF00D);
    send_pixel(0, 30, 32'h0F0F0F0F);
    send_pixel(4095, 4095, 32'hF0F0F0F0);
    push <= 1'b0;
    drain_results(QUIET);

    // Zero radius and a one column screen: only screen column 0 and rows up to the
    // bottom of the screen are written.
    write_setting(-5, 4095, 4096, 4096, 0, 24'hFFFFFF, 1, MAX_DIM, 1'b0);
    send_pixel(5, 0, 32'h00000000);
    send_pixel(6, 0, 32'hFFFFFFFF);
    send_pixel(4, 0, 32'h55AA55AA);
    send_pixel(5, 1, 32'hAA55AA55);
    push <= 1'b0;
    drain_results(QUIET);

    // A zero screen width clips every pixel; sizes beyond the nominal range are kept.
    write_setting(-4096, 0, 8191, 8191, 4096, 24'h000000, 0, MAX_DIM, 1'b0);
    send_pixel(0, 0, 32'h01020304);
    send_pixel(100, 100, 32'hFFFFFFFF);
    push <= 1'b0;
    drain_results(QUIET);

    // A zero width rectangle has no pixels inside it.
    write_setting(4095, -4096, 0, 4096, 4096, 24'h123456, MAX_DIM, 1, 1'b0);
    send_pixel(0, 0, 32'hFFFFFFFF);
    push <= 1'b0;
    drain_results(QUIET);

    // A requested radius far above half the width is clamped to it.
    write_setting(0, 0, 21, 100, 4096, 24'h5AA50F, MAX_DIM, MAX_DIM, 1'b0);
    send_pixel(0, 0, 32'hFFFFFFFF);
    send_pixel(20, 99, 32'h00000000);
    send_pixel(3, 96, 32'hFFFFFFFF);
    send_pixel(10, 50, 32'h00000000);
    push <= 1'b0;
    drain_results(QUIET);

    // Random part in three idling regimes, each over several settings.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 7;
          take_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          take_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < PHASES; ph++) begin
        random_setting();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // The receiver stalls for a long time while the sender keeps pushing, so
          // the unit fills and raises full.
          if (regime == 2 && ph == 1 && n == 5) long_hold_req = 1'b1;
          // The sender stops once until every result is out, then resumes.
          if (regime == 1 && ph == 3 && n == 40) begin
            push <= 1'b0;
            drain_results(0);
          end
          random_pixel(col, row);
          send_pixel(col, row, $urandom);
        end
        push <= 1'b0;
        drain_results(QUIET);
      end
    end

    drain_results(QUIET);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hang; far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
